### src/oaht_pkg.sv
// Shared types, codes and sizes for the open-addressing hash table unit.
// No dependencies.
package oaht_pkg;

  localparam int SLOT_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(SLOT_DEPTH);
  localparam int CNT_W      = 11;
  localparam int VALUE_W    = 32;
  localparam int HASH_W     = 32;
  localparam int DIV_W      = 11;

  // operation kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // probe modes
  localparam logic [1:0] PROBE_LINEAR = 2'd0;
  localparam logic [1:0] PROBE_QUAD   = 2'd1;
  localparam logic [1:0] PROBE_DOUBLE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PROBE_MODE   = 2'd0;
  localparam logic [1:0] REG_TABLE_SIZE   = 2'd1;
  localparam logic [1:0] REG_SECOND_PRIME = 2'd2;

  // slot states
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_FULL  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_UPDATED    = 3'd1;
  localparam logic [2:0] ST_FOUND      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_REMOVED    = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  localparam logic [CNT_W-1:0] RESET_TABLE_SIZE   = 11'd11;
  localparam logic [CNT_W-1:0] RESET_SECOND_PRIME = 11'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key_hash;
    logic [31:0]        value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [10:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [1:0]         state;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
  } slot_t;

endpackage

### src/oaht_rem.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit divisor.
// Depends on oaht_pkg.
module oaht_rem import oaht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  rem
);

  logic [31:0]      dvd_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [4:0]       cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_r, dvd_r[31]};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        dvd_r <= dividend;
        div_r <= divisor;
        rem_r <= '0;
      end else if (run_r) begin
        dvd_r <= {dvd_r[30:0], 1'b0};
        if (trial >= {1'b0, div_r}) rem_r <= diff[DIV_W-1:0];
        else rem_r <= trial[DIV_W-1:0];
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/open_addressing_hash_table_unit.sv
// Top level of the open-addressing hash table unit: sequencer, slot memory, config.
// Depends on oaht_pkg and oaht_rem.

// After reset the unit marks every slot empty, with busy high. An operation is
// taken when start is high and busy is low; busy stays high until its single
// result appears on out_data with out_valid for one cycle, which the receiver
// must take then. Each operation first reduces the hash by the table size on a
// shared bit-serial remainder unit (double hashing adds two more such passes),
// then probes slots through the slot memory, each probe a read state followed
// by a check state. The user must write configuration only while idle; the
// block itself does not enforce it.
module open_addressing_hash_table_unit import oaht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIVH, S_DIVSP, S_DIVSTEP, S_READ, S_CHECK
  } state_t;

  state_t            state_r;
  logic [1:0]        mode_r;
  logic [CNT_W-1:0]  tsize_r;
  logic [CNT_W-1:0]  sprime_r;

  logic [1:0]        kind_r;
  logic [HASH_W-1:0] hbits_r;
  logic [HASH_W-1:0] habs_r;
  logic [VALUE_W-1:0] val_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  inc_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  full_r;
  logic [ADDR_W-1:0] clr_r;
  logic              div_start_r;
  logic              out_valid_r;
  out_t              out_r;

  slot_t             mem [SLOT_DEPTH];
  slot_t             rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  slot_t             mem_wdata;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  sprime;
  logic [CNT_W-1:0]  one_mod;
  logic [31:0]       div_dvd;
  logic [DIV_W-1:0]  div_dsr;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;
  logic [HASH_W-1:0] habs_in;

  // (a + b) mod s for a, b below s, or s == 1
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b,
                                               input logic [CNT_W-1:0] s);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, s}) sum = sum - {1'b0, s};
    if (sum >= {1'b0, s}) sum = sum - {1'b0, s};
    return sum[CNT_W-1:0];
  endfunction

  // effective size, second prime, unit step and absolute hash
  always_comb begin
    size = tsize_r;
    if (size == '0) size = 11'd1;
    if (size > CNT_W'(SLOT_DEPTH)) size = CNT_W'(SLOT_DEPTH);
    sprime  = (sprime_r == '0) ? 11'd1 : sprime_r;
    one_mod = (size == 11'd1) ? 11'd0 : 11'd1;
    habs_in = in_data.key_hash[31] ? (~in_data.key_hash + 32'd1) : in_data.key_hash;
  end

  // remainder operands by phase
  always_comb begin
    div_dvd = habs_r;
    div_dsr = size;
    case (state_r)
      S_DIVSP:   div_dsr = sprime;
      S_DIVSTEP: div_dvd = {21'd0, inc_r};
      default:   ;
    endcase
  end

  oaht_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  // probe decision and slot write
  logic             hit_full;
  logic             match;
  logic             stop;
  logic [2:0]       status;
  logic [CNT_W-1:0] full_nxt;
  logic [31:0]      rd_val;

  always_comb begin
    hit_full  = rdata_r.state == SLOT_FULL;
    match     = hit_full && (rdata_r.hash == hbits_r);
    stop      = 1'b0;
    status    = (kind_r == KIND_INSERT) ? ST_TABLE_FULL : ST_NOT_FOUND;
    full_nxt  = full_r;
    rd_val    = '0;
    mem_we    = 1'b0;
    mem_waddr = pos_r[ADDR_W-1:0];
    mem_wdata = rdata_r;
    if (state_r == S_CLEAR) begin
      mem_we          = 1'b1;
      mem_waddr       = clr_r;
      mem_wdata.state = SLOT_EMPTY;
    end else if (state_r == S_CHECK) begin
      if (kind_r == KIND_INSERT) begin
        if (!hit_full || match) begin
          stop            = 1'b1;
          mem_we          = 1'b1;
          mem_wdata.state = SLOT_FULL;
          mem_wdata.hash  = hbits_r;
          mem_wdata.value = val_r;
          status          = match ? ST_UPDATED : ST_INSERTED;
          if (!match) full_nxt = full_r + 11'd1;
        end
      end else if (match) begin
        stop = 1'b1;
        if (kind_r == KIND_REMOVE) begin
          mem_we          = 1'b1;
          mem_wdata.state = SLOT_TOMB;
          status          = ST_REMOVED;
          if (full_r != '0) full_nxt = full_r - 11'd1;
        end else begin
          status = ST_FOUND;
          rd_val = rdata_r.value;
        end
      end else if (rdata_r.state == SLOT_EMPTY) begin
        stop = 1'b1;
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[pos_r[ADDR_W-1:0]];
  end

  // sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      mode_r      <= PROBE_LINEAR;
      tsize_r     <= RESET_TABLE_SIZE;
      sprime_r    <= RESET_SECOND_PRIME;
      full_r      <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_PROBE_MODE:   mode_r   <= cfg_wdata[1:0];
          REG_TABLE_SIZE:   tsize_r  <= cfg_wdata;
          REG_SECOND_PRIME: sprime_r <= cfg_wdata;
          default:          ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == {ADDR_W{1'b1}}) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_r      <= in_data.kind;
            hbits_r     <= in_data.key_hash;
            habs_r      <= habs_in;
            val_r       <= in_data.value;
            cnt_r       <= '0;
            div_start_r <= 1'b1;
            state_r     <= S_DIVH;
          end
        end
        S_DIVH: begin
          if (div_done) begin
            pos_r <= div_rem;
            inc_r <= one_mod;
            if (mode_r == PROBE_DOUBLE) begin
              div_start_r <= 1'b1;
              state_r     <= S_DIVSP;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_DIVSP: begin
          if (div_done) begin
            inc_r       <= sprime - div_rem;
            div_start_r <= 1'b1;
            state_r     <= S_DIVSTEP;
          end
        end
        S_DIVSTEP: begin
          if (div_done) begin
            inc_r   <= div_rem;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          full_r <= full_nxt;
          if (stop || cnt_r + 11'd1 == size) begin
            out_valid_r         <= 1'b1;
            out_r.status        <= status;
            out_r.read_value    <= rd_val;
            out_r.entry_count   <= full_nxt;
            state_r             <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 11'd1;
            pos_r   <= add_mod(pos_r, inc_r, size);
            if (mode_r == PROBE_QUAD) inc_r <= add_mod(inc_r, 11'd2, size);
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### tb/sv/tb.sv
// Testbench for open_addressing_hash_table_unit: directed and random table operations
// checked against an in-bench model of the slot store. Depends on oaht_pkg and the RTL.
module tb;
  import oaht_pkg::*;

  // codes outside the regular sets, used to hit the fallback behavior
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [1:0] PROBE_SPARE = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CNT_W-1:0] cfg_wdata;

  open_addressing_hash_table_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // shadow of the table and its registers
  logic [1:0]         mdl_mode;
  logic [10:0]        mdl_size;
  logic [10:0]        mdl_prime;
  logic [1:0]         mdl_state [SLOT_DEPTH];
  logic [31:0]        mdl_hash  [SLOT_DEPTH];
  logic [31:0]        mdl_value [SLOT_DEPTH];
  int unsigned        mdl_count;

  in_t  op_queue [$];
  out_t result_queue [$];
  int   mismatches;
  int   results_seen;
  int   ops_sent;
  bit   timed_out;
  bit   hold_sender;
  int   idle_cycles;

  function automatic int unsigned probe_slot(longint unsigned h, int unsigned i,
                                             int unsigned sz);
    longint unsigned p;
    longint unsigned sp;
    if (mdl_mode == PROBE_QUAD) begin
      p = h + longint'(i) * i;
    end else if (mdl_mode == PROBE_DOUBLE) begin
      sp = (mdl_prime == 0) ? 1 : mdl_prime;
      p = h + longint'(i) * (sp - (h % sp));
    end else begin
      p = h + i;
    end
    return int'(p % sz);
  endfunction

  // apply one operation to the shadow table and return its result
  function automatic out_t table_apply(in_t op);
    out_t r;
    logic [31:0] hb;
    longint unsigned h;
    int unsigned sz;
    int unsigned p;
    hb = op.key_hash;
    h = hb[31] ? longint'(32'(~hb + 1)) : longint'(hb);
    if (h == 0 && hb != 0) h = 64'h8000_0000;
    sz = (mdl_size == 0) ? 1 : (mdl_size > SLOT_DEPTH) ? SLOT_DEPTH : mdl_size;
    r.status = ST_NOT_FOUND;
    r.read_value = '0;
    if (op.kind == KIND_INSERT) begin
      r.status = ST_TABLE_FULL;
      for (int unsigned i = 0; i < sz; i++) begin
        p = probe_slot(h, i, sz);
        if (mdl_state[p] == SLOT_FULL) begin
          if (mdl_hash[p] == hb) begin
            mdl_value[p] = op.value;
            r.status = ST_UPDATED;
            break;
          end
        end else begin
          mdl_state[p] = SLOT_FULL;
          mdl_hash[p] = hb;
          mdl_value[p] = op.value;
          mdl_count++;
          r.status = ST_INSERTED;
          break;
        end
      end
    end else begin
      for (int unsigned i = 0; i < sz; i++) begin
        p = probe_slot(h, i, sz);
        if (mdl_state[p] == SLOT_FULL) begin
          if (mdl_hash[p] == hb) begin
            if (op.kind == KIND_REMOVE) begin
              mdl_state[p] = SLOT_TOMB;
              if (mdl_count > 0) mdl_count--;
              r.status = ST_REMOVED;
            end else begin
              r.read_value = mdl_value[p];
              r.status = ST_FOUND;
            end
            break;
          end
        end else if (mdl_state[p] == SLOT_EMPTY) begin
          break;
        end
      end
    end
    r.entry_count = mdl_count[10:0];
    return r;
  endfunction

  // driver: one transaction per accepted start, random gap between them
  int gap_left;
  int ops_issued;
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left = 0;
      ops_issued = 0;
    end else if (start) begin
      // the monitor counted the transaction at the last rising edge
      if (ops_sent == ops_issued) begin
        start <= 1'b0;
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
    end else if (!hold_sender && op_queue.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        in_data <= op_queue[0];
        start <= 1'b1;
        ops_issued++;
      end
    end
  end

  // monitor: accept inputs, register writes and results at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      results_seen = 0;
      ops_sent = 0;
      timed_out = 1'b0;
      idle_cycles = 0;
      mdl_mode = PROBE_LINEAR;
      mdl_size = RESET_TABLE_SIZE;
      mdl_prime = RESET_SECOND_PRIME;
      mdl_count = 0;
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        mdl_state[i] = SLOT_EMPTY;
        mdl_hash[i] = '0;
        mdl_value[i] = '0;
      end
    end else begin
      idle_cycles++;
      if (cfg_we) begin
        if (cfg_index == REG_PROBE_MODE) mdl_mode = cfg_wdata[1:0];
        else if (cfg_index == REG_TABLE_SIZE) mdl_size = cfg_wdata;
        else if (cfg_index == REG_SECOND_PRIME) mdl_prime = cfg_wdata;
      end
      if (start && !busy) begin
        result_queue.push_back(table_apply(in_data));
        void'(op_queue.pop_front());
        ops_sent++;
        idle_cycles = 0;
      end
      if (out_valid) begin
        idle_cycles = 0;
        results_seen++;
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %p", out_data);
        end else begin
          if (out_data !== result_queue[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected %p got %p", results_seen,
                       result_queue[0], out_data);
          end
          void'(result_queue.pop_front());
        end
      end
      if (idle_cycles > 20000) timed_out = 1'b1;
    end
  end

  // register write, driven at the falling edge
  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the table to drain, then let in-flight work settle
  task automatic drain();
    while ((op_queue.size() > 0 || result_queue.size() > 0 || start) && !timed_out)
      @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(int unsigned pool);
    int unsigned c;
    c = $urandom_range(0, 9);
    if (c == 0) return $urandom;
    if (c == 1) return 32'h8000_0000;
    if (c == 2) return -($urandom_range(0, pool));
    return $urandom_range(0, pool);
  endfunction

  task automatic push_op(logic [1:0] kind, logic [31:0] key, logic [31:0] val);
    in_t op;
    op.kind = kind;
    op.key_hash = key;
    op.value = val;
    op_queue.push_back(op);
  endtask

  // random phase of n operations over a small key pool
  task automatic random_phase(int n, int unsigned pool);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      push_op(k < 4 ? KIND_INSERT : k < 7 ? KIND_LOOKUP : k < 9 ? KIND_REMOVE : KIND_SPARE,
              pick_key(pool), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_sender = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: fill small table, duplicates via tombstone, table full, extremes
    hold_sender = 1'b1;
    write_reg(REG_TABLE_SIZE, 11'd2);
    hold_sender = 1'b0;
    push_op(KIND_INSERT, 32'd0, 32'hFFFF_FFFF);
    push_op(KIND_INSERT, 32'h8000_0000, 32'h0);
    push_op(KIND_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
    push_op(KIND_LOOKUP, 32'h8000_0000, 32'h0);
    push_op(KIND_INSERT, 32'd0, 32'hA5A5_A5A5);
    push_op(KIND_REMOVE, 32'd0, 32'h0);
    push_op(KIND_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    push_op(KIND_INSERT, -32'sd2, 32'h1);
    push_op(KIND_LOOKUP, 32'd7, 32'h0);
    push_op(KIND_SPARE, 32'h8000_0000, 32'hFFFF_FFFF);
    push_op(KIND_REMOVE, 32'h8000_0000, 32'h0);
    push_op(KIND_LOOKUP, 32'h8000_0000, 32'h0);
    push_op(KIND_REMOVE, 32'd5, 32'h0);
    drain();
    write_reg(REG_TABLE_SIZE, 11'd0);
    push_op(KIND_INSERT, 32'd3, 32'h9);
    push_op(KIND_LOOKUP, 32'd3, 32'h0);
    drain();
    write_reg(REG_PROBE_MODE, 11'(PROBE_SPARE));
    write_reg(REG_TABLE_SIZE, 11'd7);
    write_reg(REG_SECOND_PRIME, 11'd0);
    push_op(KIND_INSERT, 32'd14, 32'h2);
    push_op(KIND_INSERT, 32'd21, 32'h3);
    push_op(KIND_LOOKUP, 32'd21, 32'h0);
    drain();

    // random phases across register settings
    write_reg(REG_PROBE_MODE, 11'(PROBE_LINEAR));
    write_reg(REG_TABLE_SIZE, 11'd11);
    random_phase(250, 40);
    drain();
    write_reg(REG_PROBE_MODE, 11'(PROBE_QUAD));
    write_reg(REG_TABLE_SIZE, 11'd13);
    random_phase(250, 40);
    drain();
    write_reg(REG_PROBE_MODE, 11'(PROBE_DOUBLE));
    write_reg(REG_TABLE_SIZE, 11'd17);
    write_reg(REG_SECOND_PRIME, 11'd13);
    random_phase(250, 60);
    drain();
    write_reg(REG_SECOND_PRIME, 11'd1024);
    write_reg(REG_TABLE_SIZE, 11'd1024);
    random_phase(150, 3000);
    drain();
    write_reg(REG_TABLE_SIZE, 11'd2047);
    write_reg(REG_PROBE_MODE, 11'(PROBE_LINEAR));
    random_phase(150, 3000);
    drain();
    write_reg(REG_PROBE_MODE, 11'(PROBE_DOUBLE));
    write_reg(REG_TABLE_SIZE, 11'd5);
    write_reg(REG_SECOND_PRIME, 11'd3);
    random_phase(200, 12);
    drain();
    write_reg(REG_PROBE_MODE, 11'(PROBE_QUAD));
    write_reg(REG_TABLE_SIZE, 11'd3);
    random_phase(180, 8);
    drain();

    if (timed_out) begin
      $display("open_addressing_hash_table_unit verification failed");
    end else begin
      $display("Ran %0d operations, %0d results, sizes 0 to 2047, all probe modes.",
               ops_sent, results_seen);
      if (mismatches == 0 && result_queue.size() == 0)
        $display("open_addressing_hash_table_unit verification clean");
      else
        $display("open_addressing_hash_table_unit verification failed");
    end
    $finish;
  end
endmodule
